FILE: hw/rtl/sync_length_frame_parser_macros.svh
// Assertion macros shared by the frame parser RTL files.
`ifndef SYNC_LENGTH_FRAME_PARSER_MACROS_SVH
`define SYNC_LENGTH_FRAME_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SLFP_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("frame parser assertion failed");

// Check that a condition implies another in the next cycle.
`define SLFP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("frame parser assertion failed");

`endif

FILE: hw/rtl/slfp_pkg.sv
// Types and constants shared by the sync/length frame parser.
package slfp_pkg;

    // Reset values of the sync byte registers.
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'h03;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h9C;

    // Configuration register indexes.
    localparam logic [7:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] REG_SYNC_SECOND = 8'd1;

    // Frame parser phases.
    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_ID_LO  = 4'd2,
        PH_ID_HI  = 4'd3,
        PH_LEN    = 4'd4,
        PH_RECV   = 4'd5,
        PH_DATA   = 4'd6,
        PH_CHK_LO = 4'd7,
        PH_CHK_HI = 4'd8
    } phase_t;

    // One result item, produced for every received byte.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_done;
        logic [15:0] frame_id;
        logic [7:0]  frame_length;
        logic [7:0]  frame_recv_field;
        logic [15:0] frame_check;
        logic        sync_error;
    } result_t;

endpackage

FILE: hw/rtl/slfp_phase_fsm.sv
// Phase machine and header registers: one received byte per step.
`include "sync_length_frame_parser_macros.svh"

module slfp_phase_fsm
    import slfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic [7:0] sync_first,
    input  logic [7:0] sync_second,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  recv_reg, recv_next;
    logic [15:0] check_reg, check_next;

    // Hold phase and header fields, update on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            id_reg     <= 16'd0;
            recv_reg   <= 8'd0;
            check_reg  <= 16'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            id_reg     <= id_next;
            recv_reg   <= recv_next;
            check_reg  <= check_next;
        end
    end

    // Decode the byte against the current phase
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        recv_next   = recv_reg;
        check_next  = check_reg;
        result      = '0;

        case (phase_reg)
            PH_SYNC2:
            begin
                if (rx_byte == sync_second)
                begin
                    phase_next = PH_ID_LO;
                end
                else
                begin
                    result.sync_error = 1'b1;
                    phase_next        = PH_HUNT;
                end
            end
            PH_ID_LO:
            begin
                id_next    = {id_reg[15:8], rx_byte};
                phase_next = PH_ID_HI;
            end
            PH_ID_HI:
            begin
                id_next    = {rx_byte, id_reg[7:0]};
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                phase_next  = PH_RECV;
            end
            PH_RECV:
            begin
                recv_next  = rx_byte;
                // skip the payload when the frame declares none
                phase_next = (length_reg == 8'd0) ? PH_CHK_LO : PH_DATA;
            end
            PH_DATA:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                count_next           = count_reg + 8'd1;
                if (count_next >= length_reg)
                begin
                    phase_next = PH_CHK_LO;
                end
            end
            PH_CHK_LO:
            begin
                check_next = {check_reg[15:8], rx_byte};
                phase_next = PH_CHK_HI;
            end
            PH_CHK_HI:
            begin
                check_next              = {rx_byte, check_reg[7:0]};
                result.frame_done       = 1'b1;
                result.frame_id         = id_reg;
                result.frame_length     = length_reg;
                result.frame_recv_field = recv_reg;
                result.frame_check      = check_next;
                length_next             = 8'd0;
                count_next              = 8'd0;
                phase_next              = PH_HUNT;
            end
            default:
            begin
                // hunt: a matching first sync byte opens a fresh frame
                if (rx_byte == sync_first)
                begin
                    id_next     = 16'd0;
                    recv_next   = 8'd0;
                    check_next  = 16'd0;
                    length_next = 8'd0;
                    count_next  = 8'd0;
                    phase_next  = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    `SLFP_ASSERT_SAME(a_count_below_length, clk, rst_n, phase_reg == PH_DATA, count_reg < length_reg)
    `SLFP_ASSERT_NEXT(a_done_rearms, clk, rst_n, step && result.frame_done, phase_reg == PH_HUNT && count_reg == 8'd0)
    `SLFP_ASSERT_NEXT(a_error_hunts, clk, rst_n, step && result.sync_error, phase_reg == PH_HUNT)

endmodule

FILE: hw/rtl/sync_length_frame_parser.sv
// Top level of the sync/length frame parser: input stage, result stage, config.
//
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received byte per
//   request. Output channel (out_valid/out_ready and the result fields)
//   gives exactly one result per byte, in order: a payload byte, a finished
//   frame header on the last check byte, a sync error, or an all-zero idle
//   result for header and hunt bytes.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes register 0
//   (first sync byte) or 1 (second sync byte); other indexes are ignored.
//   cfg_ready is always high. Write config only while the parser is idle.
// Data path and throughput:
//   A byte is registered at the input stage, decoded by the phase machine
//   once the result stage is free, and lands in the result register. One
//   byte per cycle is sustained while out_ready is high; while a result
//   waits for out_ready, the input stage takes at most one more byte.
// Reset:
//   Both stages empty, phase back to hunting the first sync byte, sync
//   registers at 0x03 and 0x9C.
// Stall:
//   With out_ready low the result holds; one more byte is parked in the
//   input stage, then in_ready drops until the result is taken.
`include "sync_length_frame_parser_macros.svh"

module sync_length_frame_parser
    import slfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic        frame_done,
    output logic [15:0] frame_id,
    output logic [7:0]  frame_length,
    output logic [7:0]  frame_recv_field,
    output logic [15:0] frame_check,
    output logic        sync_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_result;
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       advance;

    // Move the parked byte forward when the result stage is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Write the sync byte registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Hold the input request until the decoder takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    slfp_phase_fsm u_phase_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .result      (step_result)
    );

    // Load the result register, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign payload_valid    = out_reg.payload_valid;
    assign payload_byte     = out_reg.payload_byte;
    assign payload_index    = out_reg.payload_index;
    assign frame_done       = out_reg.frame_done;
    assign frame_id         = out_reg.frame_id;
    assign frame_length     = out_reg.frame_length;
    assign frame_recv_field = out_reg.frame_recv_field;
    assign frame_check      = out_reg.frame_check;
    assign sync_error       = out_reg.sync_error;

    `SLFP_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    `SLFP_ASSERT_NEXT(a_parked_byte_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))
    `SLFP_ASSERT_SAME(a_one_kind_only, clk, rst_n, out_valid_reg, $onehot0({out_reg.payload_valid, out_reg.frame_done, out_reg.sync_error}))

endmodule
